// ----- rtl/bls_pkg.sv -----
// bls_pkg: shared codes for the Bresenham line stepper.
// No dependencies; imported by bresenham_line_stepper.
`default_nettype none

package bls_pkg;

    // request codes carried on s_req_type
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    // headroom of the error term over the coordinate width
    localparam int ERR_EXTRA = 2;

endpackage

`default_nettype wire

// ----- rtl/bresenham_line_stepper.sv -----
// Bresenham line stepper: a load beat sets up a line, each step beat yields one pixel.
// A pixel is registered and appears on the m_ channel in the cycle after its step beat is accepted.
// Throughput: one beat per cycle; error update, position step and output register share a
// single stage; s_ready stays high while the output register drains, low while it stalls.
// Reset (aresetn low, synchronous) clears the run state, so steps give nothing until a load.
// Depends on bls_pkg.
`default_nettype none

module bresenham_line_stepper #(
    parameter int COORD_BITS = 12
) (
    input  wire                    aclk,
    input  wire                    aresetn,

    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire                    s_req_type,
    input  wire [COORD_BITS-1:0]   s_x_start,
    input  wire [COORD_BITS-1:0]   s_y_start,
    input  wire [COORD_BITS-1:0]   s_x_end,
    input  wire [COORD_BITS-1:0]   s_y_end,

    output logic                   m_valid,
    input  wire                    m_ready,
    output logic [COORD_BITS-1:0]  m_pixel_x,
    output logic [COORD_BITS-1:0]  m_pixel_y,
    output logic                   m_last
);
    import bls_pkg::*;

    localparam int ERR_BITS = COORD_BITS + ERR_EXTRA;
    localparam int CMP_BITS = ERR_BITS + 1;

    // run state
    logic [COORD_BITS-1:0]        major_pos_reg, major_pos_next;
    logic [COORD_BITS-1:0]        minor_pos_reg, minor_pos_next;
    logic signed [ERR_BITS-1:0]   error_reg, error_next;
    logic [COORD_BITS-1:0]        major_delta_reg, major_delta_next;
    logic [COORD_BITS-1:0]        minor_delta_reg, minor_delta_next;
    logic [COORD_BITS-1:0]        steps_left_reg, steps_left_next;
    logic                         steep_reg, steep_next;
    logic                         minor_down_reg, minor_down_next;

    // output register
    logic                         out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0]        out_x_reg, out_x_next;
    logic [COORD_BITS-1:0]        out_y_reg, out_y_next;
    logic                         out_last_reg, out_last_next;

    logic                         accept;
    logic                         emit;

    // load datapath
    logic                         swap;
    logic [COORD_BITS-1:0]        xa, ya, xb, yb;
    logic [COORD_BITS-1:0]        dx, dy;
    logic                         falling;
    logic                         steep;

    // step datapath
    logic signed [CMP_BITS-1:0]   err_sum;
    logic signed [CMP_BITS-1:0]   err_sum2;
    logic signed [CMP_BITS-1:0]   major_ext;
    logic                         hold_minor;

    assign s_ready   = !out_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign m_valid   = out_valid_reg;
    assign m_pixel_x = out_x_reg;
    assign m_pixel_y = out_y_reg;
    assign m_last    = out_last_reg;

    always_comb begin
        swap    = s_x_end < s_x_start;
        xa      = swap ? s_x_end   : s_x_start;
        ya      = swap ? s_y_end   : s_y_start;
        xb      = swap ? s_x_start : s_x_end;
        yb      = swap ? s_y_start : s_y_end;
        dx      = xb - xa;
        falling = yb < ya;
        dy      = falling ? (ya - yb) : (yb - ya);
        steep   = dy > dx;
    end

    always_comb begin
        err_sum   = $signed({error_reg[ERR_BITS-1], error_reg})
                  + $signed({{(CMP_BITS-COORD_BITS){1'b0}}, minor_delta_reg});
        err_sum2  = {err_sum[CMP_BITS-2:0], 1'b0};
        major_ext = $signed({{(CMP_BITS-COORD_BITS){1'b0}}, major_delta_reg});
        hold_minor = err_sum2 < major_ext;
    end

    always_comb begin
        major_pos_next   = major_pos_reg;
        minor_pos_next   = minor_pos_reg;
        error_next       = error_reg;
        major_delta_next = major_delta_reg;
        minor_delta_next = minor_delta_reg;
        steps_left_next  = steps_left_reg;
        steep_next       = steep_reg;
        minor_down_next  = minor_down_reg;

        out_valid_next = out_valid_reg && !m_ready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_last_next  = out_last_reg;

        emit = accept && (s_req_type == REQ_STEP) && (steps_left_reg != '0);

        if (accept && s_req_type == REQ_LOAD) begin
            error_next = '0;
            steep_next = steep;
            if (!steep) begin
                major_pos_next   = xa;
                minor_pos_next   = ya;
                major_delta_next = dx;
                minor_delta_next = dy;
                minor_down_next  = falling;
            end else if (!falling) begin
                major_pos_next   = ya;
                minor_pos_next   = xa;
                major_delta_next = dy;
                minor_delta_next = dx;
                minor_down_next  = 1'b0;
            end else begin
                // steep falling (vertical with falling y too): walk up from the smaller row
                major_pos_next   = yb;
                minor_pos_next   = xb;
                major_delta_next = dy;
                minor_delta_next = dx;
                minor_down_next  = 1'b1;
            end
            steps_left_next = steep ? dy : dx;
        end else if (emit) begin
            out_valid_next = 1'b1;
            out_x_next     = steep_reg ? minor_pos_reg : major_pos_reg;
            out_y_next     = steep_reg ? major_pos_reg : minor_pos_reg;
            out_last_next  = steps_left_reg == COORD_BITS'(1);

            if (hold_minor) begin
                error_next = err_sum[ERR_BITS-1:0];
            end else begin
                error_next     = ERR_BITS'(err_sum - major_ext);
                minor_pos_next = minor_down_reg ? minor_pos_reg - 1'b1
                                                : minor_pos_reg + 1'b1;
            end
            major_pos_next  = major_pos_reg + 1'b1;
            steps_left_next = steps_left_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            major_pos_reg   <= '0;
            minor_pos_reg   <= '0;
            error_reg       <= '0;
            major_delta_reg <= '0;
            minor_delta_reg <= '0;
            steps_left_reg  <= '0;
            steep_reg       <= 1'b0;
            minor_down_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            major_pos_reg   <= major_pos_next;
            minor_pos_reg   <= minor_pos_next;
            error_reg       <= error_next;
            major_delta_reg <= major_delta_next;
            minor_delta_reg <= minor_delta_next;
            steps_left_reg  <= steps_left_next;
            steep_reg       <= steep_next;
            minor_down_reg  <= minor_down_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_last_reg <= out_last_next;
    end

endmodule

`default_nettype wire
